// ----- rtl/dna_transition_transversion_counter_macros.svh -----
// Assertion macros shared by the transition/transversion counter RTL.
`ifndef DNA_TRANSITION_TRANSVERSION_COUNTER_MACROS_SVH
`define DNA_TRANSITION_TRANSVERSION_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DTTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dttc check failed");

// Next-cycle implication, checked outside reset.
`define DTTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dttc check failed");

`endif

// ----- rtl/dttc_pkg.sv -----
// Package with constants, types and the popcount function of the counter.
`timescale 1ns / 1ps
package dttc_pkg;

	// Largest number of positions that one item can carry.
	localparam int MAX_POSITIONS = 32;
	// Width of a two-bit-per-position field.
	localparam int FIELD_W = 2 * MAX_POSITIONS;
	// Width of a per-item count (0 up to MAX_POSITIONS).
	localparam int ITEM_CNT_W = $clog2(MAX_POSITIONS + 1);

	// Defaults of the top-level parameters.
	localparam int DEF_POSITIONS_PER_ITEM = 32;
	localparam int DEF_COUNT_BITS = 32;

	// Masks of the popcount reduction.
	localparam logic [31:0] PAIR_BITS = 32'h55555555;
	localparam logic [31:0] PAIR_SUMS = 32'h33333333;
	localparam logic [31:0] NIBBLE_SUMS = 32'h0f0f0f0f;

	// Counts of one item, handed from the classifier to the accumulators.
	typedef struct packed {
		logic [ITEM_CNT_W-1:0] unknown;
		logic [ITEM_CNT_W-1:0] transition;
		logic [ITEM_CNT_W-1:0] transversion;
	} item_counts_t;

	// Number of set bits in a 32-bit vector, as a shallow adder tree.
	function automatic logic [ITEM_CNT_W-1:0] popcount32(input logic [31:0] v);
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] p3;
		logic [7:0] total;
		p1 = (v & PAIR_BITS) + ((v >> 1) & PAIR_BITS);
		p2 = (p1 & PAIR_SUMS) + ((p1 >> 2) & PAIR_SUMS);
		p3 = (p2 & NIBBLE_SUMS) + ((p2 >> 4) & NIBBLE_SUMS);
		total = p3[7:0] + p3[15:8] + p3[23:16] + p3[31:24];
		return total[ITEM_CNT_W-1:0];
	endfunction

endpackage

// ----- rtl/dttc_classify.sv -----
// Per-position classification of one item and the three per-item counts.
`timescale 1ns / 1ps
module dttc_classify #(
	parameter int POSITIONS_PER_ITEM = dttc_pkg::DEF_POSITIONS_PER_ITEM
) (
	input  logic [dttc_pkg::FIELD_W-1:0] seq_a,
	input  logic [dttc_pkg::FIELD_W-1:0] seq_b,
	input  logic [dttc_pkg::FIELD_W-1:0] unknown_a,
	input  logic [dttc_pkg::FIELD_W-1:0] unknown_b,
	output dttc_pkg::item_counts_t       counts
);

	logic [dttc_pkg::MAX_POSITIONS-1:0] un_bits;
	logic [dttc_pkg::MAX_POSITIONS-1:0] ts_bits;
	logic [dttc_pkg::MAX_POSITIONS-1:0] tv_bits;

	// Classify each position. Positions beyond the configured count are ignored.
	// The ORed mask bits clear the matching XOR bits, so a mask pair of 01 is
	// unknown yet may still show a transversion, as the bit-level rule gives.
	always_comb begin
		logic active;
		logic del_lo;
		logic del_hi;
		logic diff_lo;
		logic diff_hi;
		for (int p = 0; p < dttc_pkg::MAX_POSITIONS; p++) begin
			active = (p < POSITIONS_PER_ITEM);
			del_lo = (unknown_a[2*p] | unknown_b[2*p]) & active;
			del_hi = (unknown_a[2*p+1] | unknown_b[2*p+1]) & active;
			diff_lo = ~del_lo & (seq_a[2*p] ^ seq_b[2*p]) & active;
			diff_hi = ~del_hi & (seq_a[2*p+1] ^ seq_b[2*p+1]) & active;
			un_bits[p] = del_lo;
			tv_bits[p] = diff_hi;
			ts_bits[p] = diff_lo & ~diff_hi;
		end
	end

	// Count each class over the item.
	assign counts.unknown = dttc_pkg::popcount32(un_bits);
	assign counts.transition = dttc_pkg::popcount32(ts_bits);
	assign counts.transversion = dttc_pkg::popcount32(tv_bits);

endmodule

// ----- rtl/dna_transition_transversion_counter.sv -----
// Top level of the transition/transversion counter for two aligned DNA sequences.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+------------------------------------------
//   seq     | seq_valid / seq_stall     | seq_a, seq_b, unknown_a, unknown_b, last_word
//   count   | count_valid / count_stall | unknown_count, transition_count,
//           |                           | transversion_count
//
// One item per cycle while seq_stall is low: an accepted item sits in the input
// register, where the classifier, popcounts and saturating adds update the counts.
// An item with last_word set loads its result into the output register as it
// leaves the input register. The input side stalls only while a last item waits
// for a result still held by a stalled output. Reset clears the counts.
`timescale 1ns / 1ps
`include "dna_transition_transversion_counter_macros.svh"
module dna_transition_transversion_counter #(
	parameter int POSITIONS_PER_ITEM = dttc_pkg::DEF_POSITIONS_PER_ITEM,
	parameter int COUNT_BITS = dttc_pkg::DEF_COUNT_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         seq_valid,
	output logic                         seq_stall,
	input  logic [dttc_pkg::FIELD_W-1:0] seq_a,
	input  logic [dttc_pkg::FIELD_W-1:0] seq_b,
	input  logic [dttc_pkg::FIELD_W-1:0] unknown_a,
	input  logic [dttc_pkg::FIELD_W-1:0] unknown_b,
	input  logic                         last_word,
	output logic                         count_valid,
	input  logic                         count_stall,
	output logic [COUNT_BITS-1:0]        unknown_count,
	output logic [COUNT_BITS-1:0]        transition_count,
	output logic [COUNT_BITS-1:0]        transversion_count
);

	logic                         valid_s1;
	logic [dttc_pkg::FIELD_W-1:0] seq_a_s1;
	logic [dttc_pkg::FIELD_W-1:0] seq_b_s1;
	logic [dttc_pkg::FIELD_W-1:0] unknown_a_s1;
	logic [dttc_pkg::FIELD_W-1:0] unknown_b_s1;
	logic                         last_s1;

	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] unknown_count_q;
	logic [COUNT_BITS-1:0] transition_count_q;
	logic [COUNT_BITS-1:0] transversion_count_q;

	logic [COUNT_BITS-1:0] unknown_acc_q;
	logic [COUNT_BITS-1:0] transition_acc_q;
	logic [COUNT_BITS-1:0] transversion_acc_q;

	dttc_pkg::item_counts_t item_counts;
	logic [COUNT_BITS-1:0]  unknown_sum;
	logic [COUNT_BITS-1:0]  transition_sum;
	logic [COUNT_BITS-1:0]  transversion_sum;

	logic seq_accept;
	logic count_taken;
	logic advance;

	// Adds an item count to a running count, holding at the all-ones value.
	function automatic logic [COUNT_BITS-1:0] sat_add(
		input logic [COUNT_BITS-1:0]           acc,
		input logic [dttc_pkg::ITEM_CNT_W-1:0] inc
	);
		logic [COUNT_BITS:0] sum;
		sum = {1'b0, acc} + (COUNT_BITS + 1)'(inc);
		return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
	endfunction

	// Handshake control. The item in the input register leaves unless it is a
	// last item and the output register is full and stalled.
	assign seq_accept = seq_valid & ~seq_stall;
	assign count_taken = out_valid_q & ~count_stall;
	assign advance = valid_s1 & (~last_s1 | ~out_valid_q | ~count_stall);
	assign seq_stall = valid_s1 & ~advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seq_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_accept) begin
			seq_a_s1 <= seq_a;
			seq_b_s1 <= seq_b;
			unknown_a_s1 <= unknown_a;
			unknown_b_s1 <= unknown_b;
			last_s1 <= last_word;
		end
	end

	// Classification and counting of the registered item.
	dttc_classify #(
		.POSITIONS_PER_ITEM(POSITIONS_PER_ITEM)
	) u_classify (
		.seq_a(seq_a_s1),
		.seq_b(seq_b_s1),
		.unknown_a(unknown_a_s1),
		.unknown_b(unknown_b_s1),
		.counts(item_counts)
	);

	// Updated counts with this item included.
	assign unknown_sum = sat_add(unknown_acc_q, item_counts.unknown);
	assign transition_sum = sat_add(transition_acc_q, item_counts.transition);
	assign transversion_sum = sat_add(transversion_acc_q, item_counts.transversion);

	// Running counts: accumulate, or clear once a last item has been counted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unknown_acc_q <= '0;
			transition_acc_q <= '0;
			transversion_acc_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				unknown_acc_q <= '0;
				transition_acc_q <= '0;
				transversion_acc_q <= '0;
			end else begin
				unknown_acc_q <= unknown_sum;
				transition_acc_q <= transition_sum;
				transversion_acc_q <= transversion_sum;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance & last_s1) begin
			out_valid_q <= 1'b1;
		end else if (count_taken) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload, loaded with the final counts of a sequence pair.
	always_ff @(posedge clk) begin
		if (advance & last_s1) begin
			unknown_count_q <= unknown_sum;
			transition_count_q <= transition_sum;
			transversion_count_q <= transversion_sum;
		end
	end

	assign count_valid = out_valid_q;
	assign unknown_count = unknown_count_q;
	assign transition_count = transition_count_q;
	assign transversion_count = transversion_count_q;

	// A last item leaving the input register always fills the output register.
	`DTTC_ASSERT_NEXT(a_last_loads_result, clk, arst_n, advance && last_s1, out_valid_q)

	// The counts start over after a last item.
	`DTTC_ASSERT_NEXT(a_clear_after_last, clk, arst_n, advance && last_s1,
		unknown_acc_q == '0 && transition_acc_q == '0 && transversion_acc_q == '0)

	// The input side only stalls behind a blocked result.
	`DTTC_ASSERT_NOW(a_stall_cause, clk, arst_n, seq_stall,
		valid_s1 && last_s1 && out_valid_q && count_stall)

	// Counts never shrink while a sequence pair is in progress.
	`DTTC_ASSERT_NEXT(a_counts_grow, clk, arst_n, advance && !last_s1,
		unknown_acc_q >= $past(unknown_acc_q) &&
		transition_acc_q >= $past(transition_acc_q) &&
		transversion_acc_q >= $past(transversion_acc_q))

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the DNA transition/transversion counter.
`timescale 1ns / 1ps
module tb;

	localparam int POSITIONS = dttc_pkg::DEF_POSITIONS_PER_ITEM;
	localparam int CNT_W = dttc_pkg::DEF_COUNT_BITS;
	localparam int FIELD_W = dttc_pkg::FIELD_W;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 80;

	// Two-bit nucleotide codes.
	localparam logic [1:0] NT_A = 2'b00;
	localparam logic [1:0] NT_C = 2'b11;
	localparam logic [1:0] NT_G = 2'b01;
	localparam logic [1:0] NT_T = 2'b10;

	// Whole-field patterns: low bit of every pair, high bit of every pair, all bits.
	localparam logic [FIELD_W-1:0] LOW_PAIR_BITS = {2{dttc_pkg::PAIR_BITS}};
	localparam logic [FIELD_W-1:0] HIGH_PAIR_BITS = {2{dttc_pkg::PAIR_BITS}} << 1;
	localparam logic [FIELD_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic [CNT_W-1:0] unknown;
		logic [CNT_W-1:0] transition;
		logic [CNT_W-1:0] transversion;
	} counts_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seq_valid = 1'b0;
	logic seq_stall;
	logic [FIELD_W-1:0] seq_a = '0;
	logic [FIELD_W-1:0] seq_b = '0;
	logic [FIELD_W-1:0] unknown_a = '0;
	logic [FIELD_W-1:0] unknown_b = '0;
	logic last_word = 1'b0;
	logic count_valid;
	logic count_stall = 1'b0;
	logic [CNT_W-1:0] unknown_count;
	logic [CNT_W-1:0] transition_count;
	logic [CNT_W-1:0] transversion_count;

	// Running counts of the open sequence pair and the counts still owed by the block.
	counts_t running_counts = '0;
	counts_t pending_counts[$];

	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int cycles = 0;
	int hold_left = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;

	dna_transition_transversion_counter #(
		.POSITIONS_PER_ITEM(POSITIONS),
		.COUNT_BITS(CNT_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.seq_valid(seq_valid),
		.seq_stall(seq_stall),
		.seq_a(seq_a),
		.seq_b(seq_b),
		.unknown_a(unknown_a),
		.unknown_b(unknown_b),
		.last_word(last_word),
		.count_valid(count_valid),
		.count_stall(count_stall),
		.unknown_count(unknown_count),
		.transition_count(transition_count),
		.transversion_count(transversion_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle budget of the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Add to a count and hold it at its largest value.
	function automatic logic [CNT_W-1:0] saturating_add(input logic [CNT_W-1:0] acc,
			input int unsigned inc);
		logic [CNT_W:0] total;
		total = {1'b0, acc} + (CNT_W + 1)'(inc);
		return total[CNT_W] ? {CNT_W{1'b1}} : total[CNT_W-1:0];
	endfunction

	// Classify every position of one accepted item and update the running counts.
	// A set low mask bit makes the position unknown; the mask pair also clears the xor.
	// The high xor bit is classified on its own, so a position with mask pair 01
	// is unknown and can still count as a transversion.
	task automatic tally_item(input logic [FIELD_W-1:0] a, b, ua, ub, input logic last);
		logic [1:0] mask_pair;
		logic [1:0] diff_pair;
		int unsigned n_unknown;
		int unsigned n_transition;
		int unsigned n_transversion;
		n_unknown = 0;
		n_transition = 0;
		n_transversion = 0;
		for (int p = 0; p < POSITIONS; p++) begin
			mask_pair = ua[2*p +: 2] | ub[2*p +: 2];
			diff_pair = (a[2*p +: 2] ^ b[2*p +: 2]) & ~mask_pair;
			if (mask_pair[0]) begin
				n_unknown++;
			end
			if (diff_pair[1]) begin
				n_transversion++;
			end else if (diff_pair[0]) begin
				n_transition++;
			end
		end
		running_counts.unknown = saturating_add(running_counts.unknown, n_unknown);
		running_counts.transition = saturating_add(running_counts.transition, n_transition);
		running_counts.transversion =
			saturating_add(running_counts.transversion, n_transversion);
		if (last) begin
			pending_counts.push_back(running_counts);
			running_counts = '0;
		end
	endtask

	// Offer one item, with random gaps before it, and wait until the block takes it.
	task automatic send_word(input logic [FIELD_W-1:0] a, b, ua, ub, input logic last);
		@(negedge clk);
		while (tx_idle_on && $urandom_range(99) < 17) begin
			seq_valid = 1'b0;
			@(negedge clk);
		end
		seq_a = a;
		seq_b = b;
		unknown_a = ua;
		unknown_b = ub;
		last_word = last;
		seq_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (seq_stall);
		tally_item(a, b, ua, ub, last);
		items_sent++;
	endtask

	// Stop offering items until every owed result has come back.
	task automatic drain_results();
		@(negedge clk);
		seq_valid = 1'b0;
		wait (pending_counts.size() == 0);
	endtask

	// Receiver: a counted hold-off when one is requested, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			count_stall = 1'b1;
			hold_left--;
		end else begin
			count_stall = rx_idle_on && ($urandom_range(99) < 17);
		end
	end

	task automatic check_field(input string name, input logic [CNT_W-1:0] want, got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Compare each accepted result with the oldest owed counts.
	always @(posedge clk) begin
		if (arst_n && count_valid && !count_stall) begin : check_result
			counts_t want;
			if (pending_counts.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0d/%0d/%0d", $time,
					unknown_count, transition_count, transversion_count);
			end else begin
				want = pending_counts.pop_front();
				check_field("unknown_count", want.unknown, unknown_count);
				check_field("transition_count", want.transition, transition_count);
				check_field("transversion_count", want.transversion, transversion_count);
				results_checked++;
			end
		end
	end

	function automatic logic [FIELD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Unknown mask: mostly clean or sparse, sometimes fully random or all unknown.
	// Sparse masks mix the regular 11 pair with the odd 01 and 10 pairs.
	function automatic logic [FIELD_W-1:0] rand_mask();
		logic [FIELD_W-1:0] m;
		int unsigned pick;
		m = '0;
		case ($urandom_range(9))
			0, 1, 2, 3: m = '0;
			8: m = rand_word();
			9: m = ALL_ONES;
			default: begin
				for (int p = 0; p < POSITIONS; p++) begin
					pick = $urandom_range(15);
					if (pick < 2) begin
						m[2*p +: 2] = 2'b11;
					end else if (pick == 2) begin
						m[2*p +: 2] = 2'b01;
					end else if (pick == 3) begin
						m[2*p +: 2] = 2'b10;
					end
				end
			end
		endcase
		return m;
	endfunction

	// Field extremes and each mask pair, one result per item.
	task automatic test_extremes();
		send_word('0, '0, '0, '0, 1'b1);
		send_word(ALL_ONES, '0, '0, '0, 1'b1);
		send_word(LOW_PAIR_BITS, '0, '0, '0, 1'b1);
		send_word(HIGH_PAIR_BITS, '0, '0, '0, 1'b1);
		send_word(ALL_ONES, ALL_ONES, ALL_ONES, '0, 1'b1);
		send_word(ALL_ONES, '0, '0, ALL_ONES, 1'b1);
		// Low mask bit alone still marks the position unknown.
		send_word(ALL_ONES, '0, LOW_PAIR_BITS, '0, 1'b1);
		// High mask bit alone turns a transversion into a transition.
		send_word(ALL_ONES, '0, HIGH_PAIR_BITS, '0, 1'b1);
		// High mask bit alone on a high-bit difference leaves the pair equal.
		send_word(HIGH_PAIR_BITS, '0, '0, HIGH_PAIR_BITS, 1'b1);
	endtask

	// Every pairing of the four nucleotides, then counts summed over items.
	task automatic test_code_pairs();
		logic [1:0] codes [4];
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		codes = '{NT_A, NT_C, NT_G, NT_T};
		for (int p = 0; p < POSITIONS; p++) begin
			a[2*p +: 2] = codes[p % 4];
			b[2*p +: 2] = codes[(p / 4) % 4];
		end
		send_word(a, b, '0, '0, 1'b1);
		send_word(b, a, {2{32'h0000ffff}}, '0, 1'b1);
		// Several items counted into one result, the last ones back to back.
		send_word(ALL_ONES, '0, '0, '0, 1'b0);
		send_word(a, b, '0, LOW_PAIR_BITS, 1'b0);
		tx_idle_on = 1'b0;
		send_word(LOW_PAIR_BITS, ALL_ONES, '0, '0, 1'b0);
		send_word(a, ~b, HIGH_PAIR_BITS, '0, 1'b1);
		send_word(b, ~a, '0, '0, 1'b1);
		send_word('0, ALL_ONES, '0, '0, 1'b1);
		tx_idle_on = 1'b1;
	endtask

	// The receiver holds off while items keep coming, so the block fills and stalls.
	// Afterwards the sender waits for every result before going on.
	task automatic test_backpressure();
		drain_results();
		tx_idle_on = 1'b0;
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 40; i++) begin
			send_word(rand_word(), rand_word(), rand_mask(), rand_mask(), i % 2 == 1);
		end
		tx_idle_on = 1'b1;
		drain_results();
	endtask

	// Random sequence pairs of mostly short length, with a stretch free of idling.
	task automatic test_random_pairs();
		int start_items;
		int pair_len;
		int pairs;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		start_items = items_sent;
		pairs = 0;
		while (items_sent - start_items < 1000) begin
			tx_idle_on = !(items_sent - start_items inside {[400:600]});
			rx_idle_on = tx_idle_on;
			pair_len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (int i = 0; i < pair_len; i++) begin
				a = rand_word();
				b = ($urandom_range(2) == 0) ? a ^ (rand_word() & rand_word() & rand_word())
					: rand_word();
				send_word(a, b, rand_mask(), rand_mask(), i == pair_len - 1);
			end
			pairs++;
			if (pairs % 15 == 0) begin
				drain_results();
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_code_pairs();
		test_backpressure();
		test_random_pairs();
		drain_results();
		repeat (10) @(posedge clk);
		$display("Summary: %0d items sent, %0d count results compared.", items_sent,
			results_checked);
		$display("Covered field extremes, all mask pairs and code pairs, random pairs, stalls.");
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
